// File: hdl/assert_macros.svh
// Assertion macros used by the top level of the PLL register programmer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define FNPLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen on a rising clock edge outside reset.
`define FNPLL_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// File: hdl/fnpll_pkg.sv
// Types and constants of the fractional-N PLL register programmer.
package fnpll_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NUM_CFG   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FREQ_W    = 32;
  localparam int unsigned SEL_W     = 3;
  localparam logic [SEL_W-1:0] SEL_MAX = 3'd6;
  localparam int unsigned V_W       = FREQ_W + 6;
  localparam int unsigned FRAC1_W   = 24;
  localparam int unsigned FRAC2_W   = 14;
  localparam int unsigned QUOT_W    = V_W + FRAC1_W;
  localparam int unsigned ITER_W    = 6;
  localparam int unsigned SEQ_LEN   = 18;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned MOD2_VAL  = 16383;
  localparam int unsigned MOD2_SHIFT = 15;
  localparam int unsigned R6_SEL_LSB = 21;

  localparam logic [ITER_W-1:0] DIV1_ITERS = ITER_W'(QUOT_W);
  localparam logic [ITER_W-1:0] DIV2_ITERS = ITER_W'(FRAC2_W);

  localparam logic [WORD_W-1:0] R6_KEEP_MASK = 32'hFF1F_FFFF;
  localparam logic [WORD_W-1:0] R5_WORD      = 32'h0080_0025;
  localparam logic [WORD_W-1:0] R3_WORD      = 32'h0000_0003;
  localparam logic [WORD_W-1:0] AUTOCAL_BIT  = 32'h0020_0000;
  localparam logic [WORD_W-1:0] R2_FIXED     = WORD_W'((MOD2_VAL << 4) + 2);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_R12 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_R11 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_R10 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_R9  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_R8  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_R7  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_R6  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_R4  = 3'd7;

  localparam logic [NUM_CFG-1:0][WORD_W-1:0] CFG_RESET = {
    32'h3400_8984, 32'h3524_8076, 32'h1000_02E7, 32'h1A69_A6B8,
    32'h3406_7F99, 32'h6000_3EBA, 32'h0081_200B, 32'h0001_050C
  };

  typedef logic [NUM_CFG-1:0][WORD_W-1:0] cfg_bank_t;

  // Computed words of one programming request.
  typedef struct packed {
    logic [WORD_W-1:0] int_word;
    logic [WORD_W-1:0] frac1_word;
    logic [WORD_W-1:0] frac2_word;
    logic [WORD_W-1:0] divider_word;
    logic              below_range;
  } pll_words_t;

  // Slots of the write sequence, in the order the chip expects them.
  typedef enum logic [POS_W-1:0] {
    SLOT_R12, SLOT_R11, SLOT_R10, SLOT_R4_A, SLOT_R9, SLOT_R8, SLOT_R7,
    SLOT_R6, SLOT_R5, SLOT_R4_B, SLOT_R3, SLOT_R2_A, SLOT_R1_A, SLOT_R0_CAL,
    SLOT_R4_C, SLOT_R2_B, SLOT_R1_B, SLOT_R0
  } slot_e;

endpackage

// File: hdl/fnpll_serial_div.sv
// Bit-serial restoring divider, one quotient bit per clock.
module fnpll_serial_div #(
  parameter int unsigned RW = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [fnpll_pkg::QUOT_W-1:0]     num_i,
  input  logic [RW-1:0]                    rem_init_i,
  input  logic [RW-1:0]                    den_i,
  input  logic [fnpll_pkg::ITER_W-1:0]     iters_i,
  output logic [fnpll_pkg::QUOT_W-1:0]     quot_o,
  output logic [RW-1:0]                    rem_o,
  output logic                             done_o
);

  localparam int unsigned NW = fnpll_pkg::QUOT_W;

  logic [NW-1:0]                num_q;
  logic [RW-1:0]                rem_q;
  logic [RW-1:0]                den_q;
  logic [fnpll_pkg::ITER_W-1:0] cnt_q;
  logic                         busy_q;
  logic                         done_q;
  logic [RW:0]                  shifted;
  logic [RW:0]                  trial;
  logic                         fits;

  // The partial remainder stays below the divisor, so the shifted value
  // stays below twice the divisor and fits in one extra bit.
  assign shifted = {rem_q, num_q[NW-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign fits    = !trial[RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        num_q  <= num_i;
        rem_q  <= rem_init_i;
        den_q  <= den_i;
        cnt_q  <= iters_i;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        num_q <= {num_q[NW-2:0], fits};
        rem_q <= fits ? trial[RW-1:0] : shifted[RW-1:0];
        cnt_q <= cnt_q - fnpll_pkg::ITER_W'(1);
        if (cnt_q == fnpll_pkg::ITER_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quot_o = num_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

// File: hdl/fnpll_word_seq.sv
// Output sequencer that walks the eighteen-word register write sequence.
module fnpll_word_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  fnpll_pkg::pll_words_t         words_i,
  input  fnpll_pkg::cfg_bank_t          cfg_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [fnpll_pkg::WORD_W-1:0]  reg_word_o,
  output logic [fnpll_pkg::POS_W-1:0]   word_number_o,
  output logic                          below_range_o,
  output logic                          last_o,
  output logic                          done_o
);

  logic                        valid_q;
  logic [fnpll_pkg::POS_W-1:0] pos_q;
  logic                        last;

  assign last = (pos_q == fnpll_pkg::POS_W'(fnpll_pkg::SEQ_LEN - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else if (start_i) begin
      valid_q <= 1'b1;
      pos_q   <= '0;
    end else if (valid_q && !out_stall_i) begin
      if (last) begin
        valid_q <= 1'b0;
      end else begin
        pos_q <= pos_q + fnpll_pkg::POS_W'(1);
      end
    end
  end

  // The computed words stay still for the whole sequence, so they hold while
  // the receiver stalls; the configuration words follow any write to them.
  always_comb begin
    unique case (fnpll_pkg::slot_e'(pos_q))
      fnpll_pkg::SLOT_R12:    reg_word_o = cfg_i[fnpll_pkg::CFG_R12];
      fnpll_pkg::SLOT_R11:    reg_word_o = cfg_i[fnpll_pkg::CFG_R11];
      fnpll_pkg::SLOT_R10:    reg_word_o = cfg_i[fnpll_pkg::CFG_R10];
      fnpll_pkg::SLOT_R4_A:   reg_word_o = cfg_i[fnpll_pkg::CFG_R4];
      fnpll_pkg::SLOT_R9:     reg_word_o = cfg_i[fnpll_pkg::CFG_R9];
      fnpll_pkg::SLOT_R8:     reg_word_o = cfg_i[fnpll_pkg::CFG_R8];
      fnpll_pkg::SLOT_R7:     reg_word_o = cfg_i[fnpll_pkg::CFG_R7];
      fnpll_pkg::SLOT_R6:     reg_word_o = words_i.divider_word;
      fnpll_pkg::SLOT_R5:     reg_word_o = fnpll_pkg::R5_WORD;
      fnpll_pkg::SLOT_R4_B:   reg_word_o = cfg_i[fnpll_pkg::CFG_R4];
      fnpll_pkg::SLOT_R3:     reg_word_o = fnpll_pkg::R3_WORD;
      fnpll_pkg::SLOT_R2_A:   reg_word_o = words_i.frac2_word;
      fnpll_pkg::SLOT_R1_A:   reg_word_o = words_i.frac1_word;
      fnpll_pkg::SLOT_R0_CAL: reg_word_o = words_i.int_word | fnpll_pkg::AUTOCAL_BIT;
      fnpll_pkg::SLOT_R4_C:   reg_word_o = cfg_i[fnpll_pkg::CFG_R4];
      fnpll_pkg::SLOT_R2_B:   reg_word_o = words_i.frac2_word;
      fnpll_pkg::SLOT_R1_B:   reg_word_o = words_i.frac1_word;
      fnpll_pkg::SLOT_R0:     reg_word_o = words_i.int_word;
      default:                reg_word_o = '0;
    endcase
  end

  assign out_valid_o   = valid_q;
  assign word_number_o = pos_q;
  assign below_range_o = words_i.below_range;
  assign last_o        = last;
  assign done_o        = valid_q && !out_stall_i && last;

endmodule

// File: hdl/frac_n_pll_register_programmer_unit.sv
// Top level of the fractional-N PLL register programmer.
//
// The input channel takes one word, a target output frequency in MHz as
// unsigned Q16.16. For each accepted word the block picks the output divider,
// splits VCO/PFD into INT, FRAC1 and FRAC2, builds R0, R1, R2 and R6 and then
// sends the eighteen-word register write sequence on the output channel, one
// word per handshake, with the word number, the below-range flag and a last
// flag on the final word.
// Both channels use valid and stall; a word moves on a rising edge with valid
// high and stall low. The configuration port writes one of the eight fixed
// register words whenever its write enable is high.
// Steps: the output divider search, the bit-serial divider for INT and FRAC1,
// the build and load of the FRAC2 numerator, and the divider again for FRAC2,
// one quotient bit per clock, before the first output word is presented.
// A new request is taken only after the last word of the previous one.
// When the receiver stalls, the current word holds and the sequencer waits.
// Reset loads the default register words and leaves the block idle.
module frac_n_pll_register_programmer_unit #(
  parameter int unsigned PFD_MHZ     = 100,
  parameter int unsigned VCO_MIN_MHZ = 3300
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fnpll_pkg::FREQ_W-1:0]      frequency_q16_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [fnpll_pkg::WORD_W-1:0]      reg_word_o,
  output logic [fnpll_pkg::POS_W-1:0]       word_number_o,
  output logic                              below_range_o,
  output logic                              last_o,
  input  logic                              cfg_we_i,
  input  logic [fnpll_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fnpll_pkg::WORD_W-1:0]      cfg_wdata_i
);

  // The PFD frequency in Q16.16 sets the divisor width; the remainder
  // register needs one bit more to hold twice the divisor for FRAC2.
  localparam int unsigned DW  = $clog2(PFD_MHZ + 1) + 16;
  localparam int unsigned RW  = DW + 1;
  localparam int unsigned NW2 = DW + fnpll_pkg::MOD2_SHIFT;
  localparam logic [DW-1:0] D_VAL = DW'(PFD_MHZ) << 16;
  localparam logic [fnpll_pkg::V_W-1:0] VMIN_VAL =
    fnpll_pkg::V_W'(VCO_MIN_MHZ) << 16;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEL, ST_DIV1, ST_MUL, ST_ADD, ST_LOAD2, ST_DIV2, ST_EMIT
  } state_e;

  state_e                           state_q;
  fnpll_pkg::cfg_bank_t             cfg_q;
  fnpll_pkg::pll_words_t            words_q;
  logic [fnpll_pkg::V_W-1:0]        v_q;
  logic [fnpll_pkg::SEL_W-1:0]      sel_q;
  logic [NW2-1:0]                   n_q;

  logic                             in_accept;
  logic                             v_low;
  logic                             sel_done;
  logic                             div_start;
  logic [fnpll_pkg::QUOT_W-1:0]     div_num;
  logic [RW-1:0]                    div_rem_init;
  logic [RW-1:0]                    div_den;
  logic [fnpll_pkg::ITER_W-1:0]     div_iters;
  logic [fnpll_pkg::QUOT_W-1:0]     div_quot;
  logic [RW-1:0]                    div_rem;
  logic                             div_done;
  logic                             seq_start;
  logic                             seq_done;
  logic [NW2-1:0]                   r2_ext;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // Divider search: keep doubling while the VCO is low and the limit is not hit.
  assign v_low    = (v_q < VMIN_VAL);
  assign sel_done = !(v_low && (sel_q < fnpll_pkg::SEL_MAX));

  // The divider is shared: first for INT and FRAC1 over the whole VCO word
  // followed by 24 zero bits, then for the rounded FRAC2 quotient. The FRAC2
  // quotient stays below 2^14, so its top numerator bits seed the remainder.
  always_comb begin
    if (state_q == ST_LOAD2) begin
      div_num      = {n_q[fnpll_pkg::FRAC2_W-1:0],
                      (fnpll_pkg::QUOT_W - fnpll_pkg::FRAC2_W)'(0)};
      div_rem_init = n_q[NW2-1:fnpll_pkg::FRAC2_W];
      div_den      = {D_VAL, 1'b0};
      div_iters    = fnpll_pkg::DIV2_ITERS;
    end else begin
      div_num      = {v_q, fnpll_pkg::FRAC1_W'(0)};
      div_rem_init = '0;
      div_den      = {1'b0, D_VAL};
      div_iters    = fnpll_pkg::DIV1_ITERS;
    end
  end

  assign div_start = ((state_q == ST_SEL) && sel_done) || (state_q == ST_LOAD2);
  assign seq_start = (state_q == ST_DIV2) && div_done;
  assign r2_ext    = NW2'(div_rem[DW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cfg_q   <= fnpll_pkg::CFG_RESET;
      words_q <= '0;
      v_q     <= '0;
      sel_q   <= '0;
      n_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q[cfg_index_i] <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            v_q     <= fnpll_pkg::V_W'(frequency_q16_i);
            sel_q   <= '0;
            state_q <= ST_SEL;
          end
        end
        ST_SEL: begin
          if (sel_done) begin
            words_q.below_range <= v_low;
            state_q             <= ST_DIV1;
          end else begin
            v_q   <= v_q << 1;
            sel_q <= sel_q + fnpll_pkg::SEL_W'(1);
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            // R0 keeps the low 28 bits of INT above the address nibble.
            words_q.int_word <= {div_quot[fnpll_pkg::FRAC1_W +: fnpll_pkg::WORD_W - 4],
                                 4'h0};
            words_q.frac1_word <= {4'h0, div_quot[fnpll_pkg::FRAC1_W-1:0], 4'h1};
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          // 2 * r2 * 16383 as a shift and a subtract.
          n_q     <= (r2_ext << fnpll_pkg::MOD2_SHIFT) - (r2_ext << 1);
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          // Adding the divisor once makes the halved quotient round half up.
          n_q     <= n_q + NW2'(D_VAL);
          state_q <= ST_LOAD2;
        end
        ST_LOAD2: begin
          state_q <= ST_DIV2;
        end
        ST_DIV2: begin
          if (div_done) begin
            words_q.frac2_word <= {div_quot[fnpll_pkg::FRAC2_W-1:0],
                                   (fnpll_pkg::WORD_W - fnpll_pkg::FRAC2_W)'(0)}
                                  + fnpll_pkg::R2_FIXED;
            words_q.divider_word <= (cfg_q[fnpll_pkg::CFG_R6] & fnpll_pkg::R6_KEEP_MASK)
                                    | (fnpll_pkg::WORD_W'(sel_q) << fnpll_pkg::R6_SEL_LSB);
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (seq_done) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  fnpll_serial_div #(
    .RW(RW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .num_i      (div_num),
    .rem_init_i (div_rem_init),
    .den_i      (div_den),
    .iters_i    (div_iters),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  fnpll_word_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (seq_start),
    .words_i       (words_q),
    .cfg_i         (cfg_q),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .reg_word_o    (reg_word_o),
    .word_number_o (word_number_o),
    .below_range_o (below_range_o),
    .last_o        (last_o),
    .done_o        (seq_done)
  );

`include "assert_macros.svh"

  // No request is taken while a sequence is on the output.
  `FNPLL_ASSERT(a_no_accept_while_emit, out_valid_o |-> in_stall_o, "input taken during output")
  // Words of one sequence follow one another without gaps in numbering.
  `FNPLL_ASSERT(a_word_advance, (out_valid_o && !out_stall_i && !last_o) |=> (out_valid_o && (word_number_o == $past(word_number_o) + 5'd1)), "word sequence skipped")
  // The divider only reports while the controller waits for it.
  `FNPLL_NEVER(a_div_done_state, div_done && (state_q != ST_DIV1) && (state_q != ST_DIV2), "stray divider result")
  // An accepted request always leaves the block busy in the next cycle.
  `FNPLL_ASSERT(a_busy_after_accept, in_accept |=> in_stall_o, "block idle after accept")

endmodule
